@@ design/mwsm_pkg.sv @@
// ----------------------------------------------------------------------------
// mwsm_pkg
// Types, widths and codes shared by the mecanum wheel speed mixer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mwsm_pkg;

    localparam int AXIS_BITS  = 16;
    localparam int DUTY_BITS  = 8;
    localparam int WHEEL_BITS = 3;
    localparam int NUM_LANES  = 3;

    // |2v - lo - hi| <= hi - lo < 2**AXIS_BITS and |max - min| < 2**DUTY_BITS
    localparam int PROD_BITS = AXIS_BITS + DUTY_BITS;
    // sum of three quotients, each below 2**DUTY_BITS in magnitude
    localparam int SUM_BITS  = DUTY_BITS + 3;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = AXIS_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_LOW  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_HIGH = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SPEED  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SPEED  = CFG_IDX_BITS'(3);

    localparam logic [AXIS_BITS-1:0] INPUT_LOW_RST  = AXIS_BITS'(-128);
    localparam logic [AXIS_BITS-1:0] INPUT_HIGH_RST = AXIS_BITS'(127);
    localparam logic [DUTY_BITS-1:0] MIN_SPEED_RST  = DUTY_BITS'(0);
    localparam logic [DUTY_BITS-1:0] MAX_SPEED_RST  = DUTY_BITS'(255);

    localparam logic [WHEEL_BITS-1:0] WHEEL_FRONT_LEFT  = WHEEL_BITS'(1);
    localparam logic [WHEEL_BITS-1:0] WHEEL_FRONT_RIGHT = WHEEL_BITS'(2);
    localparam logic [WHEEL_BITS-1:0] WHEEL_BACK_LEFT   = WHEEL_BITS'(3);
    localparam logic [WHEEL_BITS-1:0] WHEEL_BACK_RIGHT  = WHEEL_BITS'(4);

    // lane order inside the pipeline
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_RX = 2;

    typedef struct packed {
        logic signed [AXIS_BITS-1:0] strafe;
        logic signed [AXIS_BITS-1:0] forward_axis;
        logic signed [AXIS_BITS-1:0] rotate;
        logic [WHEEL_BITS-1:0]       wheel;
    } t_in_item;

    typedef struct packed {
        logic                 forward_drive;
        logic                 backward_drive;
        logic [DUTY_BITS-1:0] duty;
        logic                 range_error;
    } t_out_item;

    typedef struct packed {
        logic [AXIS_BITS-1:0] input_low;
        logic [AXIS_BITS-1:0] input_high;
        logic [DUTY_BITS-1:0] min_speed;
        logic [DUTY_BITS-1:0] max_speed;
    } t_cfg;

    typedef struct packed {
        logic [NUM_LANES-1:0]                neg;
        logic [NUM_LANES-1:0][AXIS_BITS-1:0] mag;
        logic [WHEEL_BITS-1:0]               wheel;
        logic                                err;
    } t_map_item;

    typedef struct packed {
        logic                 neg;
        logic [PROD_BITS-1:0] rem;
        logic [DUTY_BITS-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [NUM_LANES-1:0] lane;
        logic [WHEEL_BITS-1:0]     wheel;
        logic                      err;
    } t_div_item;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                err;
    } t_sum_item;

endpackage

`default_nettype wire

@@ design/mecanum_wheel_speed_mixer_top.sv @@
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_top
// Mecanum wheel speed mixer: maps joystick axes onto one wheel's drive.
//
//   channel   signals                          dir   transfer when
//   request   i_valid, o_stall, i_item         in    i_valid && !o_stall
//   result    o_valid, i_stall, o_item         out   o_valid && !i_stall
//   config    i_cfg_we, i_cfg_idx, i_cfg_data  in    i_cfg_we
//
// one request per cycle while o_stall is low, one result per request;
// the stages are clamp, multiply, the restoring divider by
// input_high - input_low, sum, and clamp into the output register
// synchronous active-low reset empties the pipeline and loads register defaults
// a stall on the result side holds every full stage; empty stages still fill
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_speed_mixer_top
    import mwsm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire t_in_item                 i_item,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output t_out_item                     o_item,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic [AXIS_BITS:0]   w_range;
    logic [AXIS_BITS-1:0] w_divisor;

    logic      w_front_ready;
    logic      w_back_ready;
    logic      w_div_valid [DUTY_BITS+1];
    logic      w_div_ready [DUTY_BITS+1];
    t_div_item w_div_data  [DUTY_BITS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.input_low  <= INPUT_LOW_RST;
            r_cfg.input_high <= INPUT_HIGH_RST;
            r_cfg.min_speed  <= MIN_SPEED_RST;
            r_cfg.max_speed  <= MAX_SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INPUT_LOW:  r_cfg.input_low  <= i_cfg_data[AXIS_BITS-1:0];
                CFG_INPUT_HIGH: r_cfg.input_high <= i_cfg_data[AXIS_BITS-1:0];
                CFG_MIN_SPEED:  r_cfg.min_speed  <= i_cfg_data[DUTY_BITS-1:0];
                CFG_MAX_SPEED:  r_cfg.max_speed  <= i_cfg_data[DUTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input_high - input_low, positive whenever the range is valid
    assign w_range   = {r_cfg.input_high[AXIS_BITS-1], r_cfg.input_high}
                     - {r_cfg.input_low[AXIS_BITS-1], r_cfg.input_low};
    assign w_divisor = w_range[AXIS_BITS-1:0];

    assign o_stall = !w_front_ready;

    mwsm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (w_front_ready),
        .i_item  (i_item),
        .o_valid (w_div_valid[0]),
        .i_ready (w_div_ready[0]),
        .o_data  (w_div_data[0])
    );

    // quotient bits from the top down
    for (genvar j = 0; j < DUTY_BITS; j++) begin : g_div
        mwsm_div_stage #(
            .SHIFT (DUTY_BITS - 1 - j)
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (w_divisor),
            .i_valid   (w_div_valid[j]),
            .o_ready   (w_div_ready[j]),
            .i_data    (w_div_data[j]),
            .o_valid   (w_div_valid[j+1]),
            .i_ready   (w_div_ready[j+1]),
            .o_data    (w_div_data[j+1])
        );
    end

    assign w_div_ready[DUTY_BITS] = w_back_ready;

    mwsm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_div_valid[DUTY_BITS]),
        .o_ready (w_back_ready),
        .i_data  (w_div_data[DUTY_BITS]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

@@ design/mwsm_front.sv @@
// ----------------------------------------------------------------------------
// mwsm_front
// Clamps the three axes, forms the mapping numerators and their products
// with the speed span, in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_front
    import mwsm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_div_item      o_data
);

    logic      r_valid_a;
    logic      r_valid_b;
    t_map_item r_map;
    t_map_item n_map;
    t_div_item r_div;
    t_div_item n_div;
    logic      w_ready_a;
    logic      w_ready_b;

    logic signed [AXIS_BITS-1:0] w_lo;
    logic signed [AXIS_BITS-1:0] w_hi;
    logic signed [AXIS_BITS-1:0] w_axis  [NUM_LANES];
    logic signed [AXIS_BITS-1:0] w_clamp [NUM_LANES];
    logic signed [AXIS_BITS+1:0] w_off   [NUM_LANES];
    logic signed [AXIS_BITS+1:0] w_abs   [NUM_LANES];

    logic [DUTY_BITS:0]   w_span;
    logic [DUTY_BITS:0]   w_span_abs;
    logic                 w_span_neg;
    logic [DUTY_BITS-1:0] w_span_mag;

    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;
    assign o_valid   = r_valid_b;
    assign o_data    = r_div;

    assign w_lo = $signed(i_cfg.input_low);
    assign w_hi = $signed(i_cfg.input_high);

    // stage a: clamp and numerator 2v - lo - hi as sign and magnitude
    always_comb begin
        w_axis[LANE_X]  = i_item.strafe;
        w_axis[LANE_Y]  = i_item.forward_axis;
        w_axis[LANE_RX] = i_item.rotate;
        n_map.wheel = i_item.wheel;
        n_map.err   = !(w_hi > w_lo);
        for (int k = 0; k < NUM_LANES; k++) begin
            if (w_axis[k] < w_lo) begin
                w_clamp[k] = w_lo;
            end else if (w_axis[k] > w_hi) begin
                w_clamp[k] = w_hi;
            end else begin
                w_clamp[k] = w_axis[k];
            end
            w_off[k] = $signed({w_clamp[k][AXIS_BITS-1], w_clamp[k], 1'b0})
                     - $signed({{2{w_lo[AXIS_BITS-1]}}, w_lo})
                     - $signed({{2{w_hi[AXIS_BITS-1]}}, w_hi});
            w_abs[k] = w_off[k][AXIS_BITS+1] ? -w_off[k] : w_off[k];
            n_map.neg[k] = w_off[k][AXIS_BITS+1];
            n_map.mag[k] = w_abs[k][AXIS_BITS-1:0];
        end
    end

    // stage b: multiply by the span max_speed - min_speed
    assign w_span     = {1'b0, i_cfg.max_speed} - {1'b0, i_cfg.min_speed};
    assign w_span_neg = w_span[DUTY_BITS];
    assign w_span_abs = w_span_neg ? -w_span : w_span;
    assign w_span_mag = w_span_abs[DUTY_BITS-1:0];

    always_comb begin
        n_div.wheel = r_map.wheel;
        n_div.err   = r_map.err;
        for (int k = 0; k < NUM_LANES; k++) begin
            n_div.lane[k].neg = r_map.neg[k] ^ w_span_neg;
            n_div.lane[k].rem = PROD_BITS'(r_map.mag[k]) * PROD_BITS'(w_span_mag);
            n_div.lane[k].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_map <= n_map;
        end
        if (w_ready_b && r_valid_a) begin
            r_div <= n_div;
        end
    end

endmodule

`default_nettype wire

@@ design/mwsm_div_stage.sv @@
// ----------------------------------------------------------------------------
// mwsm_div_stage
// One restoring division step: settles quotient bit SHIFT in all three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_div_stage
    import mwsm_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [AXIS_BITS-1:0] i_divisor,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire t_div_item            i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_div_item                 o_data
);

    logic      r_valid;
    t_div_item r_data;
    t_div_item n_data;
    logic      w_ready;

    logic [PROD_BITS-1:0] w_step;
    logic [PROD_BITS:0]   w_diff [NUM_LANES];

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_step = PROD_BITS'(i_divisor) << SHIFT;

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < NUM_LANES; k++) begin
            w_diff[k] = {1'b0, i_data.lane[k].rem} - {1'b0, w_step};
            if (!w_diff[k][PROD_BITS]) begin
                n_data.lane[k].rem        = w_diff[k][PROD_BITS-1:0];
                n_data.lane[k].quo[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

@@ design/mwsm_back.sv @@
// ----------------------------------------------------------------------------
// mwsm_back
// Forms the wheel's mecanum sum, adds the minimum speed, clamps and splits
// the speed into direction bits and duty, in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mwsm_back
    import mwsm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cfg      i_cfg,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_div_item i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    localparam int PUSH_BITS = SUM_BITS + 1;

    logic      r_valid_a;
    logic      r_valid_b;
    t_sum_item r_sum;
    t_sum_item n_sum;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_ready_a;
    logic      w_ready_b;

    logic signed [SUM_BITS-1:0]  w_q [NUM_LANES];
    logic signed [SUM_BITS-1:0]  w_s;
    logic signed [PUSH_BITS-1:0] w_sum;
    logic signed [PUSH_BITS-1:0] w_min;
    logic signed [PUSH_BITS-1:0] w_max;
    logic signed [PUSH_BITS-1:0] w_push;
    logic signed [PUSH_BITS-1:0] w_clip;
    logic signed [PUSH_BITS-1:0] w_mag;

    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;
    assign o_valid   = r_valid_b;
    assign o_item    = r_out;

    // stage a: signed quotients and the per-wheel sum
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            w_q[k] = i_data.lane[k].neg
                   ? -$signed(SUM_BITS'(i_data.lane[k].quo))
                   :  $signed(SUM_BITS'(i_data.lane[k].quo));
        end
        case (i_data.wheel)
            WHEEL_FRONT_LEFT:  w_s = w_q[LANE_Y] + w_q[LANE_X] + w_q[LANE_RX];
            WHEEL_FRONT_RIGHT: w_s = w_q[LANE_Y] - w_q[LANE_X] - w_q[LANE_RX];
            WHEEL_BACK_LEFT:   w_s = w_q[LANE_Y] - w_q[LANE_X] + w_q[LANE_RX];
            WHEEL_BACK_RIGHT:  w_s = w_q[LANE_Y] + w_q[LANE_X] - w_q[LANE_RX];
            default:           w_s = '0;
        endcase
        n_sum.sum = w_s;
        n_sum.err = i_data.err;
    end

    // stage b: push away from zero, clamp, split into direction and duty
    assign w_sum = $signed({r_sum.sum[SUM_BITS-1], r_sum.sum});
    assign w_min = $signed({{(PUSH_BITS-DUTY_BITS){1'b0}}, i_cfg.min_speed});
    assign w_max = $signed({{(PUSH_BITS-DUTY_BITS){1'b0}}, i_cfg.max_speed});

    always_comb begin
        if (w_sum > 0) begin
            w_push = w_sum + w_min;
        end else if (w_sum < 0) begin
            w_push = w_sum - w_min;
        end else begin
            w_push = w_sum;
        end
        if (w_push > w_max) begin
            w_clip = w_max;
        end else if (w_push < -w_max) begin
            w_clip = -w_max;
        end else begin
            w_clip = w_push;
        end
        w_mag = w_clip[PUSH_BITS-1] ? -w_clip : w_clip;
        n_out.range_error    = r_sum.err;
        n_out.forward_drive  = !r_sum.err && (w_clip > 0);
        n_out.backward_drive = !r_sum.err && w_clip[PUSH_BITS-1];
        n_out.duty           = r_sum.err ? '0 : w_mag[DUTY_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_sum <= n_sum;
        end
        if (w_ready_b && r_valid_a) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
